[rtl/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranging block.
`timescale 1ns / 1ps

package uer_pkg;

	// Counter and field widths.
	localparam int COUNT_BITS = 20;
	localparam int TIMEOUT_W  = 20;
	localparam int WIDTH_W    = 20;
	localparam int DIST_W     = 16;
	localparam int STATUS_W   = 2;

	// Wide enough to hold the timeout, the counter maximum and one more.
	localparam int CMP_W = ((COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W) + 1;

	// Trigger pulse shape in ticks.
	localparam int TRIGGER_LOW_TICKS  = 2;
	localparam int TRIGGER_HIGH_TICKS = 10;

	// Distance scale: ticks per centimeter, done as a reciprocal multiply.
	localparam int TICKS_PER_CM = 58;
	localparam int DIV_SHIFT    = WIDTH_W + 8;
	localparam int MUL_W        = DIV_SHIFT + 1;
	localparam int PROD_W       = WIDTH_W + MUL_W;
	localparam logic [MUL_W-1:0] DIV_MULT = MUL_W'(((64'd1 << DIV_SHIFT)
		+ 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM));

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT_RISE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT_FALL = 2'd2;

	// Register map.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TIMEOUT    = 1'b0;
	localparam logic REG_ERROR_DIST = 1'b1;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd30000;
	localparam logic [DIST_W-1:0]    ERROR_DIST_RESET = 16'd0;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} tick_t;

	typedef struct packed {
		logic                trigger_level;
		logic                busy_res;
		logic                done_res;
		logic [STATUS_W-1:0] status;
		logic [WIDTH_W-1:0]  echo_ticks;
		logic [DIST_W-1:0]   distance_cm;
	} result_t;

endpackage

[rtl/ultrasonic_echo_ranging_top.sv]
// Top level of the ultrasonic echo ranging block: sequencer, timers and register port.
`timescale 1ns / 1ps
// A tick beat moves from the input register on to the result register as soon as the
// latter is free. Throughput: one tick beat per cycle unless the result channel stalls;
// the next-state logic and the distance multiplier form a single stage between them.
// Reset: arst_n clears the phase, counters, held results and valid flags at once;
// timeout_ticks returns to 30000 and error_distance to 0.

module ultrasonic_echo_ranging_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Tick channel
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  uer_pkg::tick_t                tick_data,
	// Result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output uer_pkg::result_t              result_data,
	// Register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [uer_pkg::ADDR_W-1:0]    paddr,
	input  logic [uer_pkg::DATA_W-1:0]    pwdata,
	output logic [uer_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	// Sequencer phases.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
	localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
	localparam logic [2:0] PH_WAIT_RISE = 3'd3;
	localparam logic [2:0] PH_WAIT_FALL = 3'd4;

	localparam logic [uer_pkg::CMP_W-1:0] CMAX =
		uer_pkg::CMP_W'((64'd1 << uer_pkg::COUNT_BITS) - 64'd1);

	// ------------------------------------------------------------------
	// Configuration registers. Writes land on the access cycle; reads are
	// decoded straight from the address.
	// ------------------------------------------------------------------
	logic [uer_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [uer_pkg::DIST_W-1:0]    error_dist_q;
	logic                          cfg_wr;
	logic                          cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= uer_pkg::TIMEOUT_RESET;
			error_dist_q <= uer_pkg::ERROR_DIST_RESET;
		end else if (cfg_wr) begin
			case (cfg_sel)
				uer_pkg::REG_TIMEOUT: begin
					timeout_q <= pwdata[uer_pkg::TIMEOUT_W-1:0];
				end
				uer_pkg::REG_ERROR_DIST: begin
					error_dist_q <= pwdata[uer_pkg::DIST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			uer_pkg::REG_TIMEOUT:    prdata = uer_pkg::DATA_W'(timeout_q);
			uer_pkg::REG_ERROR_DIST: prdata = uer_pkg::DATA_W'(error_dist_q);
			default:                 prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control. The input register takes a new beat whenever the
	// stage below can move, so a full result register waiting on a stall
	// does not block a tick unless both stages are occupied.
	// ------------------------------------------------------------------
	logic              valid_s1;
	uer_pkg::tick_t    tick_s1;
	logic              result_valid_q;
	uer_pkg::result_t  result_q;
	logic              out_free;
	logic              adv_s1;
	logic              take_tick;

	assign out_free   = !result_valid_q || !result_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign take_tick  = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_tick) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_tick) begin
			tick_s1 <= tick_data;
		end
	end

	// ------------------------------------------------------------------
	// Measurement state.
	// ------------------------------------------------------------------
	logic [2:0]                      phase_q, phase_d;
	logic [uer_pkg::COUNT_BITS-1:0]  cnt_q, cnt_d;
	logic                            echo_prev_q;
	logic [uer_pkg::STATUS_W-1:0]    held_status_q, held_status_d;
	logic [uer_pkg::WIDTH_W-1:0]     held_width_q, held_width_d;
	logic [uer_pkg::DIST_W-1:0]      held_dist_q, held_dist_d;

	logic                            rise, fall;
	logic [uer_pkg::CMP_W-1:0]       timeout_ext, limit, elapsed;
	logic                            trig, busy, done;
	logic                            fin;
	logic [uer_pkg::STATUS_W-1:0]    fin_status;
	logic [uer_pkg::WIDTH_W-1:0]     fin_width;
	logic [uer_pkg::PROD_W-1:0]      prod;
	logic [uer_pkg::WIDTH_W:0]       quot;
	logic [uer_pkg::DIST_W-1:0]      quot_sat;

	assign rise = tick_s1.echo_level && !echo_prev_q;
	assign fall = !tick_s1.echo_level && echo_prev_q;

	// The wait limit is the timeout, clipped to what the counter can hold.
	assign timeout_ext = uer_pkg::CMP_W'(timeout_q);
	assign limit       = (timeout_ext < CMAX) ? timeout_ext : CMAX;
	assign elapsed     = uer_pkg::CMP_W'(cnt_q) + uer_pkg::CMP_W'(1);

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		trig       = 1'b0;
		busy       = 1'b1;
		done       = 1'b0;
		fin        = 1'b0;
		fin_status = uer_pkg::ST_OK;
		fin_width  = '0;
		case (phase_q)
			PH_TRIG_LOW: begin
				if (elapsed >= uer_pkg::CMP_W'(uer_pkg::TRIGGER_LOW_TICKS)) begin
					phase_d = PH_TRIG_HIGH;
					cnt_d   = '0;
				end else begin
					cnt_d = uer_pkg::COUNT_BITS'(elapsed);
				end
			end
			PH_TRIG_HIGH: begin
				trig = 1'b1;
				if (elapsed >= uer_pkg::CMP_W'(uer_pkg::TRIGGER_HIGH_TICKS)) begin
					phase_d = PH_WAIT_RISE;
					cnt_d   = '0;
				end else begin
					cnt_d = uer_pkg::COUNT_BITS'(elapsed);
				end
			end
			PH_WAIT_RISE: begin
				// An edge on the same tick as the timeout still counts.
				if (rise) begin
					phase_d = PH_WAIT_FALL;
					cnt_d   = '0;
				end else if (elapsed > limit) begin
					fin        = 1'b1;
					fin_status = uer_pkg::ST_TIMEOUT_RISE;
				end else begin
					cnt_d = uer_pkg::COUNT_BITS'(elapsed);
				end
			end
			PH_WAIT_FALL: begin
				if (fall) begin
					fin        = 1'b1;
					fin_status = uer_pkg::ST_OK;
					fin_width  = (elapsed > limit) ? uer_pkg::WIDTH_W'(limit)
						: uer_pkg::WIDTH_W'(elapsed);
				end else if (elapsed > limit) begin
					fin        = 1'b1;
					fin_status = uer_pkg::ST_TIMEOUT_FALL;
				end else begin
					cnt_d = uer_pkg::COUNT_BITS'(elapsed);
				end
			end
			default: begin
				// Idle, and any unused code, behaves as idle.
				if (tick_s1.start_req) begin
					phase_d = PH_TRIG_LOW;
					cnt_d   = uer_pkg::COUNT_BITS'(1);
				end else begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
					busy    = 1'b0;
				end
			end
		endcase
		if (fin) begin
			phase_d = PH_IDLE;
			cnt_d   = '0;
			busy    = 1'b0;
			done    = 1'b1;
		end
	end

	// Width over ticks-per-cm by multiplying with a rounded-up reciprocal;
	// the error stays below one for every width the counter can produce.
	assign prod     = uer_pkg::PROD_W'(fin_width) * uer_pkg::PROD_W'(uer_pkg::DIV_MULT);
	assign quot     = (uer_pkg::WIDTH_W + 1)'(prod >> uer_pkg::DIV_SHIFT);
	assign quot_sat = (quot > (uer_pkg::WIDTH_W + 1)'({uer_pkg::DIST_W{1'b1}}))
		? {uer_pkg::DIST_W{1'b1}} : uer_pkg::DIST_W'(quot);

	always_comb begin
		held_status_d = held_status_q;
		held_width_d  = held_width_q;
		held_dist_d   = held_dist_q;
		if (fin) begin
			held_status_d = fin_status;
			held_width_d  = fin_width;
			held_dist_d   = (fin_width == '0) ? error_dist_q : quot_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			cnt_q         <= '0;
			echo_prev_q   <= 1'b0;
			held_status_q <= uer_pkg::ST_OK;
			held_width_q  <= '0;
			held_dist_q   <= '0;
		end else if (adv_s1) begin
			phase_q       <= phase_d;
			cnt_q         <= cnt_d;
			echo_prev_q   <= tick_s1.echo_level;
			held_status_q <= held_status_d;
			held_width_q  <= held_width_d;
			held_dist_q   <= held_dist_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register. Every tick beat yields exactly one result beat.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.trigger_level <= trig;
			result_q.busy_res      <= busy;
			result_q.done_res      <= done;
			result_q.status        <= held_status_d;
			result_q.echo_ticks    <= held_width_d;
			result_q.distance_cm   <= held_dist_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// While waiting for an echo edge the counter never passes the limit.
	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT_RISE || phase_q == PH_WAIT_FALL)
			|-> (uer_pkg::CMP_W'(cnt_q) <= limit))
		else $error("wait counter beyond limit");

	// A finishing tick is never reported as busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.done_res && result_q.busy_res))
		else $error("done and busy in one result");

	// The result beat shows the same held values as the held registers.
	a_held_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (result_q.echo_ticks == held_width_q
			&& result_q.status == held_status_q
			&& result_q.distance_cm == held_dist_q))
		else $error("result held fields disagree with held state");

	// A stalled tick beat keeps the input register occupied.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |=> valid_s1)
		else $error("input register dropped a stalled beat");

	// Trigger is high only while the sequencer sits in the trigger-high phase.
	a_trig_phase: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (phase_q != PH_TRIG_HIGH) |=> !result_q.trigger_level)
		else $error("trigger high outside the pulse");

endmodule

[dv/tb_ultrasonic_echo_ranging_top.sv]
// Testbench for the ultrasonic echo ranging block: tick streams checked beat by beat against a predictor.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranging_top;
	import uer_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 12;
	// Far beyond the slowest passing run.
	localparam int CYCLE_LIMIT   = 400000;
	// Idle cycles after the last result beat before the registers are next written.
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS   = 40;
	localparam int PHASE_TICKS   = 55;
	// Tick beats after the start beat until the block begins to wait for the echo rise.
	localparam int TRIGGER_TICKS = TRIGGER_LOW_TICKS - 1 + TRIGGER_HIGH_TICKS;

	typedef enum logic [2:0] {
		RNG_IDLE,
		RNG_TRIG_LOW,
		RNG_TRIG_HIGH,
		RNG_WAIT_RISE,
		RNG_WAIT_FALL
	} ranging_phase_e;

	// The scoreboard carries its own copy of the ranging sequencer. Every accepted tick beat
	// advances that copy and queues the result beat the block must produce for it.
	class echo_scoreboard;
		result_t              pending_readings[$];
		int unsigned          errors;
		ranging_phase_e       phase;
		longint unsigned      tick_count;
		logic                 echo_prev;
		logic [STATUS_W-1:0]  held_status;
		logic [WIDTH_W-1:0]   held_width;
		logic [DIST_W-1:0]    held_dist;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [DIST_W-1:0]    error_distance;

		function new();
			errors = 0;
			phase = RNG_IDLE;
			tick_count = 0;
			echo_prev = 1'b0;
			held_status = ST_OK;
			held_width = '0;
			held_dist = '0;
			timeout_ticks = TIMEOUT_RESET;
			error_distance = ERROR_DIST_RESET;
		endfunction

		function void close_measurement(logic [STATUS_W-1:0] st, longint unsigned width);
			longint unsigned clipped;
			longint unsigned dist_cm;
			clipped = (width > (64'd1 << WIDTH_W) - 1) ? (64'd1 << WIDTH_W) - 1 : width;
			held_status = st;
			held_width = WIDTH_W'(clipped);
			if (clipped == 0) begin
				dist_cm = error_distance;
			end else begin
				dist_cm = clipped / TICKS_PER_CM;
				if (dist_cm > (64'd1 << DIST_W) - 1)
					dist_cm = (64'd1 << DIST_W) - 1;
			end
			held_dist = DIST_W'(dist_cm);
			phase = RNG_IDLE;
			tick_count = 0;
		endfunction

		function void note_tick(tick_t t);
			result_t         r;
			logic            rise;
			logic            fall;
			longint unsigned cmax;
			longint unsigned lim;
			longint unsigned elapsed;
			cmax = (64'd1 << COUNT_BITS) - 1;
			lim = (timeout_ticks < cmax) ? timeout_ticks : cmax;
			rise = t.echo_level && !echo_prev;
			fall = !t.echo_level && echo_prev;
			r.trigger_level = 1'b0;
			r.busy_res = 1'b1;
			r.done_res = 1'b0;
			case (phase)
				RNG_TRIG_LOW: begin
					tick_count++;
					if (tick_count >= TRIGGER_LOW_TICKS) begin
						phase = RNG_TRIG_HIGH;
						tick_count = 0;
					end
				end
				RNG_TRIG_HIGH: begin
					r.trigger_level = 1'b1;
					tick_count++;
					if (tick_count >= TRIGGER_HIGH_TICKS) begin
						phase = RNG_WAIT_RISE;
						tick_count = 0;
					end
				end
				RNG_WAIT_RISE: begin
					elapsed = tick_count + 1;
					if (rise) begin
						phase = RNG_WAIT_FALL;
						tick_count = 0;
					end else if (elapsed > lim) begin
						close_measurement(ST_TIMEOUT_RISE, 0);
						r.busy_res = 1'b0;
						r.done_res = 1'b1;
					end else begin
						tick_count = elapsed;
					end
				end
				RNG_WAIT_FALL: begin
					elapsed = tick_count + 1;
					// The edge wins over a timeout on the same tick; the width is clipped to the limit.
					if (fall) begin
						close_measurement(ST_OK, (elapsed > lim) ? lim : elapsed);
						r.busy_res = 1'b0;
						r.done_res = 1'b1;
					end else if (elapsed > lim) begin
						close_measurement(ST_TIMEOUT_FALL, 0);
						r.busy_res = 1'b0;
						r.done_res = 1'b1;
					end else begin
						tick_count = elapsed;
					end
				end
				default: begin
					phase = RNG_IDLE;
					if (t.start_req) begin
						phase = RNG_TRIG_LOW;
						tick_count = 1;
					end else begin
						tick_count = 0;
						r.busy_res = 1'b0;
					end
				end
			endcase
			echo_prev = t.echo_level;
			r.status = held_status;
			r.echo_ticks = held_width;
			r.distance_cm = held_dist;
			pending_readings.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				if (errors < MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_reading(result_t got);
			result_t want;
			if (pending_readings.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: result beat with none expected, expected nothing, actual %p",
						$time, got);
				errors++;
			end else begin
				want = pending_readings.pop_front();
				compare_field("trigger_level", 64'(want.trigger_level), 64'(got.trigger_level));
				compare_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
				compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
				compare_field("status", 64'(want.status), 64'(got.status));
				compare_field("echo_ticks", 64'(want.echo_ticks), 64'(got.echo_ticks));
				compare_field("distance_cm", 64'(want.distance_cm), 64'(got.distance_cm));
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 tick_stall;
	tick_t                tick_data = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result_data;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	int unsigned          tx_idle_pct = 0;
	int unsigned          rx_stall_pct = 0;
	longint unsigned      cycle_count = 0;
	tick_t                tick_q[$];
	echo_scoreboard       sb;

	ultrasonic_echo_ranging_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick_data    (tick_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake or a lost result beat ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: every beat taken at this edge is checked, then the stall for the next
	// cycle is drawn. Values read here are those from before the edge.
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			sb.check_reading(result_data);
		result_stall <= ($urandom_range(99, 0) < rx_stall_pct);
	end

	function automatic logic coin(int unsigned pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			1: begin
				tx_idle_pct = 48;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct = 48;
			end
			default: begin
				tx_idle_pct = 37;
				rx_stall_pct = 37;
			end
		endcase
	endtask

	// One register transfer: a setup cycle, then an access cycle that completes on pready.
	task automatic reg_access(input logic write, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Writes both registers, reads them back, and moves the predictor to the new setting.
	task automatic configure(logic [TIMEOUT_W-1:0] timeout, logic [DIST_W-1:0] err);
		logic [DATA_W-1:0] rd;
		logic [ADDR_W-1:0] timeout_addr;
		logic [ADDR_W-1:0] err_addr;
		timeout_addr = ADDR_W'({REG_TIMEOUT, 2'b00});
		err_addr = ADDR_W'({REG_ERROR_DIST, 2'b00});
		reg_access(1'b1, timeout_addr, DATA_W'(timeout), rd);
		reg_access(1'b1, err_addr, DATA_W'(err), rd);
		sb.timeout_ticks = timeout;
		sb.error_distance = err;
		reg_access(1'b0, timeout_addr, '0, rd);
		sb.compare_field("timeout_ticks readback", 64'(timeout), 64'(rd));
		reg_access(1'b0, err_addr, '0, rd);
		sb.compare_field("error_distance readback", 64'(err), 64'(rd));
	endtask

	// Sends every queued tick beat. The predictor steps at the edge that takes each beat,
	// and valid is only touched when the slot is free, so a stalled beat stays put.
	task automatic drive_ticks();
		while (tick_q.size() != 0 || tick_valid) begin
			@(posedge clk);
			if (tick_valid && !tick_stall)
				sb.note_tick(tick_data);
			if (!tick_valid || !tick_stall) begin
				if (tick_q.size() != 0 && !coin(tx_idle_pct)) begin
					tick_valid <= 1'b1;
					tick_data <= tick_q.pop_front();
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	endtask

	// A start beat, the trigger pulse with echo noise, then an echo that stays high for
	// pre ticks, low for gap ticks, high for high ticks and then drops. The last trigger
	// tick is high exactly when pre is nonzero, so that a held-high echo is not seen as a rise.
	task automatic queue_measurement(int pre, int gap, int high, logic busy_starts);
		tick_q.push_back('{start_req: 1'b1, echo_level: 1'($urandom)});
		for (int i = 0; i < TRIGGER_TICKS; i++) begin
			tick_q.push_back('{start_req: busy_starts & coin(50),
				echo_level: (i == TRIGGER_TICKS - 1) ? (pre > 0) : 1'($urandom)});
		end
		repeat (pre) tick_q.push_back('{start_req: busy_starts & coin(50), echo_level: 1'b1});
		repeat (gap) tick_q.push_back('{start_req: busy_starts & coin(50), echo_level: 1'b0});
		repeat (high) tick_q.push_back('{start_req: busy_starts & coin(50), echo_level: 1'b1});
		tick_q.push_back('{start_req: busy_starts & coin(50), echo_level: 1'b0});
	endtask

	// Mostly well-formed measurements sized around the timeout, so that small timeouts
	// see both waits run out, with idle noise and the odd burst of junk in between.
	task automatic queue_random_measurement(logic [TIMEOUT_W-1:0] timeout);
		int lim;
		int pre;
		int gap;
		int high;
		lim = (timeout < 16) ? int'(timeout) : 12;
		pre = coin(25) ? $urandom_range(3, 1) : 0;
		gap = $urandom_range(lim + 2, 0);
		high = coin(10) ? 0 : $urandom_range(lim + 2, 1);
		queue_measurement(pre, gap, high, coin(30));
		repeat ($urandom_range(3, 0))
			tick_q.push_back('{start_req: 1'b0, echo_level: 1'($urandom)});
		if (coin(12)) begin
			repeat (6) tick_q.push_back('{start_req: 1'($urandom), echo_level: 1'($urandom)});
		end
	endtask

	// Sends the queued beats, then steers any open measurement to its end: in a wait the
	// echo is toggled, which yields the awaited edge within two ticks. Then every result
	// beat is collected so that the registers may be written next.
	task automatic finish_phase();
		drive_ticks();
		while (sb.phase != RNG_IDLE) begin
			tick_q.push_back('{start_req: 1'b0,
				echo_level: (sb.phase == RNG_WAIT_RISE || sb.phase == RNG_WAIT_FALL) ?
					~sb.echo_prev : 1'b0});
			drive_ticks();
		end
		while (sb.pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase(logic [TIMEOUT_W-1:0] timeout, logic [DIST_W-1:0] err,
			int mode);
		configure(timeout, err);
		set_idling(mode);
		while (tick_q.size() < PHASE_TICKS)
			queue_random_measurement(timeout);
		finish_phase();
	endtask

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings: idle beats at both echo levels, then one measurement with
		// starts while busy, echo edges during the trigger pulse, and an echo already high
		// when the rise wait begins.
		set_idling(0);
		tick_q.push_back('{start_req: 1'b0, echo_level: 1'b1});
		tick_q.push_back('{start_req: 1'b0, echo_level: 1'b0});
		queue_measurement(1, 1, 3, 1'b1);
		finish_phase();

		// Directed, zero timeout: the echo rises on the first wait tick and falls on the next,
		// which gives a zero width and the largest error distance.
		configure('0, '1);
		set_idling(3);
		queue_measurement(0, 0, 1, 1'b0);
		finish_phase();

		// Random phases over the register extremes and values in between, one idling
		// pattern each.
		run_random_phase(TIMEOUT_RESET, 16'($urandom), 0);
		run_random_phase('0, '1, 1);
		run_random_phase('1, '0, 2);
		run_random_phase(TIMEOUT_W'($urandom_range(12, 1)), 16'($urandom), 3);
		run_random_phase(TIMEOUT_W'($urandom_range(60, 13)), 16'($urandom), 0);
		run_random_phase(TIMEOUT_W'($urandom), 16'($urandom), 1);

		if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
